[rtl/core/ssg_pkg.sv]
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared constants, types and helper functions for the signed square-root
// sigmoid gate: fixed-point formats, range reduction tables, root step.
// ----------------------------------------------------------------------------
package ssg_pkg;

  // Port formats
  localparam int SCORE_W       = 24;
  localparam int GATE_W        = 16;
  localparam int IN_FRAC_BITS  = 16;
  localparam int OUT_FRAC_BITS = 16;

  // Square root: radicand is |x| in Q.(2*ROOT_FRAC), root in Q.ROOT_FRAC
  localparam int ROOT_FRAC = 16;
  localparam int SQ_SHIFT  = 2 * ROOT_FRAC - IN_FRAC_BITS;
  localparam int SQ_RAW_W  = SCORE_W + SQ_SHIFT;
  localparam int SQ_W      = 2 * ((SQ_RAW_W + 1) / 2);
  localparam int ROOT_W    = SQ_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam logic [SQ_W-1:0] FLOOR_SQ = SQ_W'(4295);

  // Range reduction by ln2 in Q32
  localparam logic [63:0] LN2_Q32 = 64'd2977044472;
  localparam int THR_W     = 32;
  localparam int RED_SHIFT = 32 - ROOT_FRAC;
  localparam longint unsigned RED_ROUND = (64'd1 << RED_SHIFT) - 64'd1;
  localparam int N_LIMIT   = 30;
  localparam int N_W       = $clog2(N_LIMIT + 1);

  // Taylor series for exp in Q30
  localparam int EXP_FRAC     = 30;
  localparam logic [63:0] ONE_Q30 = 64'd1 << EXP_FRAC;
  localparam int R_W          = EXP_FRAC;
  localparam int TERM_W       = EXP_FRAC + 1;
  localparam int E_W          = EXP_FRAC + 2;
  localparam int TAYLOR_TERMS = 12;
  localparam int K_W          = $clog2(TAYLOR_TERMS + 1);
  localparam int RECIP_SHIFT  = 32;
  localparam int RECIP_W      = RECIP_SHIFT + 1;
  localparam int P_W          = TERM_W + R_W;
  localparam int X_W          = P_W - R_W;
  localparam int Y_W          = X_W + RECIP_W;

  // Reciprocal of 1 + E*2^n
  localparam int DEN_W = E_W + N_LIMIT;
  localparam int Q_W   = OUT_FRAC_BITS + 1;
  localparam int DIV_W = DEN_W + Q_W;

  // Control that travels with each item
  typedef struct packed {
    logic valid;
    logic neg;
    logic tail_zero;
  } ssg_tag_t;

  // Partial state of the digit-by-digit square root
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_acc_t;

  // One root digit: bring down two radicand bits, try 4*root+1
  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t acc, logic [1:0] pair);
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    sqrt_acc_t        res;
    cur   = {acc.rem[REM_W-3:0], pair};
    trial = {acc.root, 2'b01};
    if (cur >= trial) begin
      res.rem  = cur - trial;
      res.root = {acc.root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = cur;
      res.root = {acc.root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

  // Smallest root t with t * 2^RED_SHIFT >= k * ln2
  function automatic logic [THR_W-1:0] red_thr(int k);
    longint unsigned prod;
    prod = longint'(k) * LN2_Q32;
    return THR_W'((prod + RED_ROUND) >> RED_SHIFT);
  endfunction

  // n * ln2 in Q32
  function automatic logic [63:0] ln2_mult(logic [N_W-1:0] n);
    return 64'(n) * LN2_Q32;
  endfunction

endpackage

[rtl/core/ssg_sqrt.sv]
// ----------------------------------------------------------------------------
// ssg_sqrt
// Magnitude, floor and pipelined integer square root, one root bit per
// stage. The sign rides along in the item tag.
// ----------------------------------------------------------------------------
module ssg_sqrt
  import ssg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [SCORE_W-1:0] score,
  output ssg_tag_t                  tag_out,
  output logic [ROOT_W-1:0]         root
);

  logic               neg;
  logic [SCORE_W-1:0] mag;
  logic [SQ_W-1:0]    sq;
  logic [SQ_W-1:0]    sq_floor;
  ssg_tag_t           tag_front;

  ssg_tag_t        tag_q [ROOT_W];
  sqrt_acc_t       acc_q [ROOT_W];
  logic [SQ_W-1:0] rad_q [ROOT_W];

  // |x| scaled to the radicand format, floored at 1e-6
  always_comb begin
    neg       = score[SCORE_W-1];
    mag       = neg ? $unsigned(-score) : $unsigned(score);
    sq        = SQ_W'({mag, {SQ_SHIFT{1'b0}}});
    sq_floor  = (sq < FLOOR_SQ) ? FLOOR_SQ : sq;
    tag_front = '{valid: in_valid, neg: neg, tail_zero: 1'b0};
  end

  // Root stages, top radicand pair first
  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    sqrt_acc_t       acc_prev;
    logic [SQ_W-1:0] rad_prev;
    ssg_tag_t        tag_prev;

    if (i == 0) begin : g_head
      assign acc_prev = '0;
      assign rad_prev = sq_floor;
      assign tag_prev = tag_front;
    end else begin : g_chain
      assign acc_prev = acc_q[i-1];
      assign rad_prev = rad_q[i-1];
      assign tag_prev = tag_q[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_q[i] <= '0;
      end else if (en) begin
        tag_q[i] <= tag_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_q[i] <= sqrt_step(acc_prev, rad_prev[SQ_W-1 -: 2]);
        rad_q[i] <= rad_prev << 2;
      end
    end
  end

  assign tag_out = tag_q[ROOT_W-1];
  assign root    = acc_q[ROOT_W-1].root;

endmodule

[rtl/core/ssg_exp.sv]
// ----------------------------------------------------------------------------
// ssg_exp
// Splits |r| into n*ln2 + rem, then evaluates exp(rem) in Q30 with a
// 12-term Taylor series, three stages per term (multiply, reciprocal
// multiply, correct and accumulate).
// ----------------------------------------------------------------------------
module ssg_exp
  import ssg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  ssg_tag_t          tag_in,
  input  logic [ROOT_W-1:0] root,
  output ssg_tag_t          tag_out,
  output logic [E_W-1:0]    e_val,
  output logic [N_W-1:0]    n_val
);

  // Range reduction registers
  ssg_tag_t           tag_r1;
  ssg_tag_t           tag_r2;
  ssg_tag_t           tag_r3;
  logic [ROOT_W-1:0]  root_r1;
  logic [ROOT_W-1:0]  root_r2;
  logic [N_LIMIT-1:0] cmp;
  logic [N_LIMIT-1:0] cmp_r1;
  logic [N_W-1:0]     cnt;
  logic [N_W-1:0]     n_r2;
  logic [N_W-1:0]     n_r3;
  logic [63:0]        big;
  logic [63:0]        rem;
  logic [R_W-1:0]     r_r3;

  // Taylor stage registers
  logic [P_W-1:0]    p_a    [TAYLOR_TERMS];
  logic [X_W-1:0]    x_b    [TAYLOR_TERMS];
  logic [Y_W-1:0]    y_b    [TAYLOR_TERMS];
  logic [TERM_W-1:0] term_c [TAYLOR_TERMS];
  logic [R_W-1:0]    r_a    [TAYLOR_TERMS];
  logic [R_W-1:0]    r_b    [TAYLOR_TERMS];
  logic [R_W-1:0]    r_c    [TAYLOR_TERMS];
  logic [E_W-1:0]    sum_a  [TAYLOR_TERMS];
  logic [E_W-1:0]    sum_b  [TAYLOR_TERMS];
  logic [E_W-1:0]    sum_c  [TAYLOR_TERMS];
  logic [N_W-1:0]    n_a    [TAYLOR_TERMS];
  logic [N_W-1:0]    n_b    [TAYLOR_TERMS];
  logic [N_W-1:0]    n_c    [TAYLOR_TERMS];
  ssg_tag_t          tag_a  [TAYLOR_TERMS];
  ssg_tag_t          tag_b  [TAYLOR_TERMS];
  ssg_tag_t          tag_c  [TAYLOR_TERMS];

  // n as a thermometer: root against each multiple of ln2
  always_comb begin
    for (int k = 0; k < N_LIMIT; k++) begin
      cmp[k] = THR_W'(root) >= red_thr(k + 1);
    end
  end

  // Count of passed thresholds, saturating at the tail-zero limit
  always_comb begin
    cnt = '0;
    for (int k = 0; k < N_LIMIT; k++) begin
      cnt = cnt + N_W'(cmp_r1[k]);
    end
  end

  // Remainder in Q32, kept as Q30
  always_comb begin
    big = 64'({root_r2, {RED_SHIFT{1'b0}}});
    rem = big - ln2_mult(n_r2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_r1 <= '0;
      tag_r2 <= '0;
      tag_r3 <= '0;
    end else if (en) begin
      tag_r1 <= tag_in;
      tag_r2 <= '{valid: tag_r1.valid, neg: tag_r1.neg, tail_zero: cmp_r1[N_LIMIT-1]};
      tag_r3 <= tag_r2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_r1 <= root;
      cmp_r1  <= cmp;
      root_r2 <= root_r1;
      n_r2    <= cnt;
      n_r3    <= n_r2;
      r_r3    <= rem[R_W+1:2];
    end
  end

  // term_k = ((term_{k-1} * r) >> 30) / k, sum += term_k
  for (genvar i = 0; i < TAYLOR_TERMS; i++) begin : g_term
    localparam int K = i + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / K);

    logic [TERM_W-1:0]     term_prev;
    logic [R_W-1:0]        r_prev;
    logic [E_W-1:0]        sum_prev;
    logic [N_W-1:0]        n_prev;
    ssg_tag_t              tag_prev;
    logic [TERM_W-1:0]     q0;
    logic [TERM_W+K_W-1:0] resid;
    logic [TERM_W-1:0]     term;

    if (i == 0) begin : g_head
      assign term_prev = TERM_W'(ONE_Q30);
      assign r_prev    = r_r3;
      assign sum_prev  = E_W'(ONE_Q30);
      assign n_prev    = n_r3;
      assign tag_prev  = tag_r3;
    end else begin : g_chain
      assign term_prev = term_c[i-1];
      assign r_prev    = r_c[i-1];
      assign sum_prev  = sum_c[i-1];
      assign n_prev    = n_c[i-1];
      assign tag_prev  = tag_c[i-1];
    end

    // Reciprocal estimate is exact or one low; fix it with one compare
    always_comb begin
      q0    = TERM_W'(y_b[i][Y_W-1:RECIP_SHIFT]);
      resid = (TERM_W+K_W)'(x_b[i]) - (TERM_W+K_W)'(q0) * (TERM_W+K_W)'(K);
      term  = (resid >= (TERM_W+K_W)'(K)) ? q0 + 1'b1 : q0;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_a[i] <= '0;
        tag_b[i] <= '0;
        tag_c[i] <= '0;
      end else if (en) begin
        tag_a[i] <= tag_prev;
        tag_b[i] <= tag_a[i];
        tag_c[i] <= tag_b[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_a[i]    <= P_W'(term_prev) * P_W'(r_prev);
        r_a[i]    <= r_prev;
        sum_a[i]  <= sum_prev;
        n_a[i]    <= n_prev;
        x_b[i]    <= p_a[i][P_W-1:R_W];
        y_b[i]    <= Y_W'(p_a[i][P_W-1:R_W]) * Y_W'(RECIP);
        r_b[i]    <= r_a[i];
        sum_b[i]  <= sum_a[i];
        n_b[i]    <= n_a[i];
        term_c[i] <= term;
        sum_c[i]  <= sum_b[i] + E_W'(term);
        r_c[i]    <= r_b[i];
        n_c[i]    <= n_b[i];
      end
    end
  end

  assign tag_out = tag_c[TAYLOR_TERMS-1];
  assign e_val   = sum_c[TAYLOR_TERMS-1];
  assign n_val   = n_c[TAYLOR_TERMS-1];

endmodule

[rtl/core/ssg_div.sv]
// ----------------------------------------------------------------------------
// ssg_div
// Tail q = round(2^(30+OUT_FRAC_BITS) / (E*2^n + 2^30)) by a restoring
// divider, one quotient bit per stage, then sign fold and saturation into
// the output register.
// ----------------------------------------------------------------------------
module ssg_div
  import ssg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  ssg_tag_t          tag_in,
  input  logic [E_W-1:0]    e_val,
  input  logic [N_W-1:0]    n_val,
  output logic              gate_valid,
  output logic [GATE_W-1:0] gate
);

  localparam logic [DEN_W-1:0] NUM_ONE = DEN_W'(1) << (EXP_FRAC + OUT_FRAC_BITS);
  localparam logic [OUT_FRAC_BITS:0] FULL = (OUT_FRAC_BITS+1)'(1) << OUT_FRAC_BITS;

  ssg_tag_t         tag_d0;
  ssg_tag_t         tag_d1;
  logic [DEN_W-1:0] den_d0;
  logic [DEN_W-1:0] den_d1;
  logic [DEN_W-1:0] num_d1;

  ssg_tag_t         tag_q [Q_W];
  logic [DEN_W-1:0] rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];

  logic [Q_W-1:0]         q;
  logic [OUT_FRAC_BITS:0] g;

  // Divisor, then dividend with half the divisor for rounding
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_d0 <= '0;
      tag_d1 <= '0;
    end else if (en) begin
      tag_d0 <= tag_in;
      tag_d1 <= tag_d0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_d0 <= (DEN_W'(e_val) << n_val) + DEN_W'(ONE_Q30);
      den_d1 <= den_d0;
      num_d1 <= NUM_ONE + (den_d0 >> 1);
    end
  end

  // Quotient bits, most significant first
  for (genvar j = 0; j < Q_W; j++) begin : g_bit
    localparam int SH = Q_W - 1 - j;

    ssg_tag_t         tag_prev;
    logic [DEN_W-1:0] rem_prev;
    logic [DEN_W-1:0] den_prev;
    logic [Q_W-1:0]   quo_prev;
    logic [DIV_W-1:0] dd;
    logic             fit;

    if (j == 0) begin : g_head
      assign tag_prev = tag_d1;
      assign rem_prev = num_d1;
      assign den_prev = den_d1;
      assign quo_prev = '0;
    end else begin : g_chain
      assign tag_prev = tag_q[j-1];
      assign rem_prev = rem_q[j-1];
      assign den_prev = den_q[j-1];
      assign quo_prev = quo_q[j-1];
    end

    assign dd  = DIV_W'(den_prev) << SH;
    assign fit = DIV_W'(rem_prev) >= dd;

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_q[j] <= '0;
      end else if (en) begin
        tag_q[j] <= tag_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= fit ? DEN_W'(DIV_W'(rem_prev) - dd) : rem_prev;
        den_q[j] <= den_prev;
        quo_q[j] <= {quo_prev[Q_W-2:0], fit};
      end
    end
  end

  // Negative score takes the tail, others take one minus the tail
  always_comb begin
    q = tag_q[Q_W-1].tail_zero ? '0 : quo_q[Q_W-1];
    g = tag_q[Q_W-1].neg ? q : FULL - q;
    if (g > FULL - 1'b1) begin
      g = FULL - 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_valid <= 1'b0;
    end else if (en) begin
      gate_valid <= tag_q[Q_W-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gate <= GATE_W'(g);
    end
  end

endmodule

[rtl/core/signed_sqrt_sigmoid_gate_core.sv]
// ----------------------------------------------------------------------------
// signed_sqrt_sigmoid_gate_core
// Elementwise gate: sigmoid of sign(x)*sqrt(max(|x|, 1e-6)) for a Q8.16
// score, returned as an unsigned Q0.16 fraction saturated at 65535.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                   payload
//  score    in         score_valid / score_stall   score  [23:0] signed Q8.16
//  gate     out        gate_valid  / gate_stall    gate   [15:0] unsigned Q0.16
//
//  One item per cycle sustained while no output item is held; the pipeline holds
//  the 20 root digit stages, 36 Taylor stages and the 17-stage quotient divider.
//  Reset clears every valid bit; payload is not reset.
//  A stalled output item freezes the whole pipeline in place and raises
//  score_stall in the same cycle; bubbles move through as empty slots.
// ----------------------------------------------------------------------------
module signed_sqrt_sigmoid_gate_core
  import ssg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      score_valid,
  output logic                      score_stall,
  input  logic signed [SCORE_W-1:0] score,
  output logic                      gate_valid,
  input  logic                      gate_stall,
  output logic [GATE_W-1:0]         gate
);

  logic              en;
  ssg_tag_t          sq_tag;
  ssg_tag_t          ex_tag;
  logic [ROOT_W-1:0] root;
  logic [E_W-1:0]    e_val;
  logic [N_W-1:0]    n_val;

  // Pipeline advances unless the output item is held
  assign en          = !(gate_valid && gate_stall);
  assign score_stall = !en;

  ssg_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (score_valid),
    .score    (score),
    .tag_out  (sq_tag),
    .root     (root)
  );

  ssg_exp u_exp (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tag_in  (sq_tag),
    .root    (root),
    .tag_out (ex_tag),
    .e_val   (e_val),
    .n_val   (n_val)
  );

  ssg_div u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .tag_in     (ex_tag),
    .e_val      (e_val),
    .n_val      (n_val),
    .gate_valid (gate_valid),
    .gate       (gate)
  );

endmodule

[rtl/core/ssg_checker.sv]
// ----------------------------------------------------------------------------
// ssg_checker
// Port-level checks on the gate core: reset, stall coupling, a held input
// item and a held output item. Attached to the top level by bind.
// ----------------------------------------------------------------------------
module ssg_checker
  import ssg_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      score_valid,
  input logic                      score_stall,
  input logic signed [SCORE_W-1:0] score,
  input logic                      gate_valid,
  input logic                      gate_stall,
  input logic [GATE_W-1:0]         gate
);

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !gate_valid)
    else $error("gate_valid high after reset");

  // Input is held back exactly when an output item waits
  a_stall_couple: assert property (@(posedge clk) disable iff (rst)
    score_stall == (gate_valid && gate_stall))
    else $error("score_stall does not follow a held output item");

  // Free output means the input side takes items
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (!gate_valid || !gate_stall) |-> !score_stall)
    else $error("score_stall raised with free output");

  // A stalled input item stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (score_valid && score_stall) |=> (score_valid && $stable(score)))
    else $error("stalled input item changed");

  // A held output item keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (gate_valid && gate_stall) |=> (gate_valid && $stable(gate)))
    else $error("held output item changed");

endmodule

bind signed_sqrt_sigmoid_gate_core ssg_checker u_ssg_checker (.*);

[tb/signed_sqrt_sigmoid_gate_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_sqrt_sigmoid_gate_core_test
// Streams Q8.16 scores through the gate core and checks every gate in order
// against an integer predictor of sigmoid(sign(x)*sqrt(max(|x|, 1e-6))).
// Directed corner scores come first, then random scores in two phases, with
// random gaps and stalls on both channels, two long output hold-offs and a full
// drain between phases.
// ----------------------------------------------------------------------------
module signed_sqrt_sigmoid_gate_core_test;
  import ssg_pkg::*;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [GATE_W-1:0]  gate;
  } gate_entry_t;

  logic                      clk;
  logic                      rst         = 1'b1;
  logic                      score_valid = 1'b0;
  logic                      score_stall;
  logic signed [SCORE_W-1:0] score       = '0;
  logic                      gate_valid;
  logic                      gate_stall  = 1'b0;
  logic [GATE_W-1:0]         gate;

  logic signed [SCORE_W-1:0] pending_scores[$];
  gate_entry_t               expected_gates[$];
  int                        mismatch_count = 0;
  int                        gates_seen     = 0;
  int                        send_gap       = 0;
  int                        send_quiet     = 0;
  int                        recv_hold      = 0;
  int                        recv_quiet     = 0;

  signed_sqrt_sigmoid_gate_core uut (
    .clk         (clk),
    .rst         (rst),
    .score_valid (score_valid),
    .score_stall (score_stall),
    .score       (score),
    .gate_valid  (gate_valid),
    .gate_stall  (gate_stall),
    .gate        (gate)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gate for one score: integer root, ln2 range reduction, Taylor exp in
  // Q30, rounded reciprocal of the tail, then mirror for non-negative input.
  function automatic logic [GATE_W-1:0] predict_gate(logic [SCORE_W-1:0] x);
    logic            neg;
    longint unsigned mag, rad, root, trial, scaled, n, rem, term, e, den, tail;
    longint unsigned full, g;
    neg = x[SCORE_W-1];
    mag = 64'(x);
    if (neg) mag = (64'd1 << SCORE_W) - mag;
    rad = mag << (2 * ROOT_FRAC - IN_FRAC_BITS);
    if (rad < 64'(FLOOR_SQ)) rad = 64'(FLOOR_SQ);
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= rad) root = trial;
    end
    scaled = root << (32 - ROOT_FRAC);
    n      = scaled / LN2_Q32;
    rem    = scaled - n * LN2_Q32;
    if (n >= N_LIMIT) begin
      tail = 0;
    end else begin
      term = 64'd1 << EXP_FRAC;
      e    = term;
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
        term = ((term * (rem >> 2)) >> EXP_FRAC) / k;
        e    = e + term;
      end
      den  = (e << n) + (64'd1 << EXP_FRAC);
      tail = ((64'd1 << (EXP_FRAC + OUT_FRAC_BITS)) + (den >> 1)) / den;
    end
    full = 64'd1 << OUT_FRAC_BITS;
    g = neg ? tail : full - tail;
    if (g > full - 1) g = full - 1;
    return g[GATE_W-1:0];
  endfunction

  // Per-item wait: mostly a random draw, with runs of items that never wait
  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // Random score: full range, near zero, tiny, or near either extreme
  function automatic logic [SCORE_W-1:0] rand_score();
    int v;
    case ($urandom_range(0, 4))
      0, 1: v = int'($urandom);
      2:    v = int'($urandom_range(0, 262144)) - 131072;
      3:    v = int'($urandom_range(0, 128)) - 64;
      default: begin
        v = int'($urandom_range(0, 255));
        v = $urandom_range(0, 1) ? 8388607 - v : -8388608 + v;
      end
    endcase
    return SCORE_W'(v);
  endfunction

  // Wait until nothing is queued, offered or outstanding
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_scores.size() != 0 || score_valid || expected_gates.size() != 0);
  endtask

  // Score driver: predicts each accepted item, then offers the next one
  always @(posedge clk) begin
    if (rst) begin
      score_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (score_valid && !score_stall)
        expected_gates.push_back(gate_entry_t'{score: score, gate: predict_gate(score)});
      if (!score_valid || !score_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          score_valid <= 1'b0;
        end else if (pending_scores.size() != 0) begin
          score       <= pending_scores.pop_front();
          score_valid <= 1'b1;
          send_gap = draw_wait(send_quiet);
        end else begin
          score_valid <= 1'b0;
        end
      end
    end
  end

  // Gate monitor: in-order compare, random stalls, two long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      gate_stall <= 1'b0;
      recv_hold = 0;
    end else begin
      if (gate_valid && !gate_stall) begin
        gates_seen++;
        if (expected_gates.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected gate: expected none, got %0d", $time, gate);
        end else begin
          gate_entry_t want;
          want = expected_gates.pop_front();
          if (gate !== want.gate) begin
            mismatch_count++;
            $display("%0t: gate mismatch for score %0d: expected %0d, got %0d",
                     $time, $signed(want.score), want.gate, gate);
          end
        end
        if (gates_seen == 60 || gates_seen == 330) recv_hold = 400;
        else recv_hold = draw_wait(recv_quiet);
      end
      if (recv_hold > 0) begin
        recv_hold--;
        gate_stall <= 1'b1;
      end else begin
        gate_stall <= 1'b0;
      end
    end
  end

  // Stimulus
  initial begin
    logic signed [SCORE_W-1:0] corner[$];
    corner = '{24'sd0, 24'sd1, -24'sd1, 24'sd2, -24'sd2,
                24'sd8388607, -24'sd8388608, 24'sd8388606, -24'sd8388607,
                24'sd65536, -24'sd65536, 24'sd4194304, -24'sd4194304,
                24'sd31486, 24'sd31487, 24'sd31488, -24'sd31487, -24'sd31488,
                24'sh555555, 24'shAAAAAA, 24'sd131071, -24'sd131072};
    foreach (corner[i]) pending_scores.push_back(corner[i]);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Random phase one, then let the pipe drain completely
    for (int i = 0; i < 270; i++) pending_scores.push_back(rand_score());
    wait_drained();
    for (int i = 0; i < 260; i++) pending_scores.push_back(rand_score());
    wait_drained();
    repeat (100) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #800000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
